[rtl/e2q_pkg.sv]
// Shared types, constants and helper functions for the Euler-angle to quaternion core.
// Used by every module under rtl; depends on nothing else.
package e2q_pkg;

  // Default widths of the angle inputs and of the quaternion components.
  localparam int DEF_ANGLE_BITS     = 16;
  localparam int DEF_COMPONENT_BITS = 16;

  // The CORDIC datapath runs in Q2.30 with two guard bits of headroom.
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 34;
  localparam int TRIG_W       = 32;
  localparam int PROD_W       = 2 * TRIG_W;
  localparam int SUM_W        = TRIG_W + 1;
  localparam int OUT_W        = 35;

  localparam logic signed [CORDIC_W-1:0] Q30_ONE_GAIN = 34'sh26DD3B6A;
  localparam logic signed [PROD_W-1:0]   Q30_HALF_LSB = 64'sd536870912;

  // Component order in the packed result word.
  localparam int COMP_W = 0;
  localparam int COMP_X = 1;
  localparam int COMP_Y = 2;
  localparam int COMP_Z = 3;
  localparam int NUM_COMPS = 4;
  localparam int NUM_ANGLES = 3;

  // Cosine and sine of one half angle, Q2.30.
  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  // Arctangent of 2^-i in units of 2^32 per full turn.
  function automatic logic signed [CORDIC_W-1:0] atan_step(input int idx);
    logic [31:0] val;
    begin
      unique case (idx)
        0:  val = 32'h20000000;
        1:  val = 32'h12E4051E;
        2:  val = 32'h09FB385B;
        3:  val = 32'h051111D4;
        4:  val = 32'h028B0D43;
        5:  val = 32'h0145D7E1;
        6:  val = 32'h00A2F61E;
        7:  val = 32'h00517C55;
        8:  val = 32'h0028BE53;
        9:  val = 32'h00145F2F;
        10: val = 32'h000A2F98;
        11: val = 32'h000517CC;
        12: val = 32'h00028BE6;
        13: val = 32'h000145F3;
        14: val = 32'h0000A2FA;
        15: val = 32'h0000517D;
        16: val = 32'h000028BE;
        17: val = 32'h0000145F;
        18: val = 32'h00000A30;
        19: val = 32'h00000518;
        20: val = 32'h0000028C;
        21: val = 32'h00000146;
        22: val = 32'h000000A3;
        23: val = 32'h00000051;
        24: val = 32'h00000029;
        25: val = 32'h00000014;
        26: val = 32'h0000000A;
        27: val = 32'h00000005;
        28: val = 32'h00000003;
        default: val = 32'h00000001;
      endcase
      return $signed({2'b00, val});
    end
  endfunction

  // Q2.30 product rescale: floor((p + 2^29) / 2^30), kept to 32 bits.
  function automatic logic signed [TRIG_W-1:0] q30_round(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    begin
      t = p + Q30_HALF_LSB;
      return $signed(t[TRIG_W+29:30]);
    end
  endfunction

endpackage

[rtl/e2q_cordic.sv]
// Three-lane rotation-mode CORDIC, one register stage per iteration.
// Depends on e2q_pkg for the arctangent table, gain constant and trig_t.
module e2q_cordic #(
  parameter int ANGLE_BITS = e2q_pkg::DEF_ANGLE_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [ANGLE_BITS-1:0]   angle_i [e2q_pkg::NUM_ANGLES],
  output logic                    valid_o,
  output e2q_pkg::trig_t          trig_o [e2q_pkg::NUM_ANGLES]
);
  import e2q_pkg::*;

  logic signed [CORDIC_W-1:0] z0 [NUM_ANGLES];

  logic signed [CORDIC_W-1:0] x_i [CORDIC_STEPS][NUM_ANGLES];
  logic signed [CORDIC_W-1:0] y_i [CORDIC_STEPS][NUM_ANGLES];
  logic signed [CORDIC_W-1:0] z_i [CORDIC_STEPS][NUM_ANGLES];
  logic signed [CORDIC_W-1:0] x_d [CORDIC_STEPS][NUM_ANGLES];
  logic signed [CORDIC_W-1:0] y_d [CORDIC_STEPS][NUM_ANGLES];
  logic signed [CORDIC_W-1:0] z_d [CORDIC_STEPS][NUM_ANGLES];
  logic signed [CORDIC_W-1:0] x_q [CORDIC_STEPS][NUM_ANGLES];
  logic signed [CORDIC_W-1:0] y_q [CORDIC_STEPS][NUM_ANGLES];
  logic signed [CORDIC_W-1:0] z_q [CORDIC_STEPS][NUM_ANGLES];
  logic [CORDIC_STEPS-1:0]    valid_q;

  // Half angle in 2^32 units per turn.
  for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_phase
    if (ANGLE_BITS < 32) begin : g_scale
      assign z0[l] = CORDIC_W'($signed(angle_i[l])) <<< (31 - ANGLE_BITS);
    end else begin : g_halve
      assign z0[l] = CORDIC_W'($signed(angle_i[l]) >>> 1);
    end
  end

  // One micro-rotation per stage; the direction follows the sign of z.
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_stage
    for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_lane
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      if (s == 0) begin : g_first
        assign x_i[s][l] = Q30_ONE_GAIN;
        assign y_i[s][l] = '0;
        assign z_i[s][l] = z0[l];
      end else begin : g_next
        assign x_i[s][l] = x_q[s-1][l];
        assign y_i[s][l] = y_q[s-1][l];
        assign z_i[s][l] = z_q[s-1][l];
      end
      assign dx = y_i[s][l] >>> s;
      assign dy = x_i[s][l] >>> s;
      assign x_d[s][l] = z_i[s][l][CORDIC_W-1] ? x_i[s][l] + dx : x_i[s][l] - dx;
      assign y_d[s][l] = z_i[s][l][CORDIC_W-1] ? y_i[s][l] - dy : y_i[s][l] + dy;
      assign z_d[s][l] = z_i[s][l][CORDIC_W-1] ? z_i[s][l] + atan_step(s)
                                                : z_i[s][l] - atan_step(s);
    end
  end

  // Datapath registers move only when the pipeline advances.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < CORDIC_STEPS; s++) begin
        for (int l = 0; l < NUM_ANGLES; l++) begin
          x_q[s][l] <= x_d[s][l];
          y_q[s][l] <= y_d[s][l];
          z_q[s][l] <= z_d[s][l];
        end
      end
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[CORDIC_STEPS-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[CORDIC_STEPS-1];

  for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_out
    assign trig_o[l].cos_v = x_q[CORDIC_STEPS-1][l][TRIG_W-1:0];
    assign trig_o[l].sin_v = y_q[CORDIC_STEPS-1][l][TRIG_W-1:0];
  end

endmodule

[rtl/e2q_quat.sv]
// Quaternion assembly: two registered multiply rounds, sums, then rounding and saturation.
// Depends on e2q_pkg for trig_t, component order and the Q2.30 rescale.
module e2q_quat #(
  parameter int COMPONENT_BITS = e2q_pkg::DEF_COMPONENT_BITS
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  input  logic                                      valid_i,
  input  e2q_pkg::trig_t                            trig_i [e2q_pkg::NUM_ANGLES],
  output logic                                      valid_o,
  output logic [e2q_pkg::NUM_COMPS*COMPONENT_BITS-1:0] comp_o
);
  import e2q_pkg::*;

  localparam int F = COMPONENT_BITS - 1;
  localparam int NUM_STAGES = 5;

  logic signed [TRIG_W-1:0] c1, s1, c2, s2;

  // Stage 1: products of the first two angles.
  logic signed [PROD_W-1:0] p_cc_q, p_ss_q, p_sc_q, p_cs_q;
  logic signed [TRIG_W-1:0] c3_1_q, s3_1_q;
  // Stage 2: rescaled pair products.
  logic signed [TRIG_W-1:0] a_cc_q, a_ss_q, a_sc_q, a_cs_q;
  logic signed [TRIG_W-1:0] c3_2_q, s3_2_q;
  // Stage 3: triple products.
  logic signed [PROD_W-1:0] t_ccc_q, t_sss_q, t_scc_q, t_css_q;
  logic signed [PROD_W-1:0] t_csc_q, t_scs_q, t_ccs_q, t_ssc_q;
  // Stage 4: component sums.
  logic signed [SUM_W-1:0]  sum_q [NUM_COMPS];
  logic signed [SUM_W-1:0]  sum_d [NUM_COMPS];
  // Stage 5: output components.
  logic [COMPONENT_BITS-1:0] comp_d [NUM_COMPS];
  logic [COMPONENT_BITS-1:0] comp_q [NUM_COMPS];
  logic [NUM_STAGES-1:0]     valid_q;

  assign c1 = $signed(trig_i[0].cos_v);
  assign s1 = $signed(trig_i[0].sin_v);
  assign c2 = $signed(trig_i[1].cos_v);
  assign s2 = $signed(trig_i[1].sin_v);

  // Rescaled triple products and the four sums.
  always_comb begin
    logic signed [TRIG_W-1:0] r_ccc, r_sss, r_scc, r_css, r_csc, r_scs, r_ccs, r_ssc;
    r_ccc = q30_round(t_ccc_q);
    r_sss = q30_round(t_sss_q);
    r_scc = q30_round(t_scc_q);
    r_css = q30_round(t_css_q);
    r_csc = q30_round(t_csc_q);
    r_scs = q30_round(t_scs_q);
    r_ccs = q30_round(t_ccs_q);
    r_ssc = q30_round(t_ssc_q);
    sum_d[COMP_W] = SUM_W'(r_ccc) - SUM_W'(r_sss);
    sum_d[COMP_X] = SUM_W'(r_scc) + SUM_W'(r_css);
    sum_d[COMP_Y] = SUM_W'(r_csc) - SUM_W'(r_scs);
    sum_d[COMP_Z] = SUM_W'(r_ccs) + SUM_W'(r_ssc);
  end

  // Round each sum to the component format and saturate.
  for (genvar k = 0; k < NUM_COMPS; k++) begin : g_fmt
    localparam logic signed [OUT_W-1:0] HI = (35'sd1 <<< F) - 35'sd1;
    localparam logic signed [OUT_W-1:0] LO = -(35'sd1 <<< F);
    logic signed [OUT_W-1:0] v;
    if (F < 30) begin : g_round
      localparam logic signed [OUT_W-1:0] RND = 35'sd1 <<< (29 - F);
      assign v = (OUT_W'(sum_q[k]) + RND) >>> (30 - F);
    end else if (F == 30) begin : g_keep
      assign v = OUT_W'(sum_q[k]);
    end else begin : g_double
      assign v = OUT_W'(sum_q[k]) <<< 1;
    end
    always_comb begin
      priority if (v > HI) begin
        comp_d[k] = HI[COMPONENT_BITS-1:0];
      end else if (v < LO) begin
        comp_d[k] = LO[COMPONENT_BITS-1:0];
      end else begin
        comp_d[k] = v[COMPONENT_BITS-1:0];
      end
    end
  end

  // Pipeline datapath.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_cc_q  <= c1 * c2;
      p_ss_q  <= s1 * s2;
      p_sc_q  <= s1 * c2;
      p_cs_q  <= c1 * s2;
      c3_1_q  <= $signed(trig_i[2].cos_v);
      s3_1_q  <= $signed(trig_i[2].sin_v);

      a_cc_q  <= q30_round(p_cc_q);
      a_ss_q  <= q30_round(p_ss_q);
      a_sc_q  <= q30_round(p_sc_q);
      a_cs_q  <= q30_round(p_cs_q);
      c3_2_q  <= c3_1_q;
      s3_2_q  <= s3_1_q;

      t_ccc_q <= a_cc_q * c3_2_q;
      t_sss_q <= a_ss_q * s3_2_q;
      t_scc_q <= a_sc_q * c3_2_q;
      t_css_q <= a_cs_q * s3_2_q;
      t_csc_q <= a_cs_q * c3_2_q;
      t_scs_q <= a_sc_q * s3_2_q;
      t_ccs_q <= a_cc_q * s3_2_q;
      t_ssc_q <= a_ss_q * c3_2_q;

      sum_q   <= sum_d;
      comp_q  <= comp_d;
    end
  end

  // Valid bits for the five stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NUM_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[NUM_STAGES-1];
  assign comp_o  = {comp_q[COMP_Z], comp_q[COMP_Y], comp_q[COMP_X], comp_q[COMP_W]};

endmodule

[rtl/e2q_out_skid.sv]
// Output register with one skid entry, so the pipeline keeps moving while a word waits.
// Depends on no package contents beyond its own width parameter.
module e2q_out_skid #(
  parameter int DATA_W = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [DATA_W-1:0] data_o
);
  import e2q_pkg::*;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              skid_valid_q;
  logic [DATA_W-1:0] skid_data_q;
  logic              out_free;

  // The pipeline may advance whenever the skid entry is empty.
  assign ready_o  = !skid_valid_q;
  assign out_free = !out_valid_q || ready_i;

  // Control: the skid entry drains first, otherwise the pipeline word goes straight out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || valid_i;
      skid_valid_q <= 1'b0;
    end else if (valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : data_i;
    end else if (valid_i && !skid_valid_q) begin
      skid_data_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

endmodule

[rtl/euler_to_quaternion_core.sv]
// Euler angles to unit quaternion: the stream top level.
// Depends on e2q_pkg, e2q_cordic, e2q_quat and e2q_out_skid.
//
// Each input word holds three signed binary angles (value v stands for v*pi/2^(ANGLE_BITS-1)
// radians); each result word holds the quaternion w, x, y, z in signed Q1.(COMPONENT_BITS-1),
// with +1.0 saturating to the largest code. The block takes one word per clock unless the
// input is stalled and returns results in order through 30 CORDIC iteration stages, which set
// the depth, then the first multiply round, its rescale stage, the second multiply round, a
// stage that rescales the triple products and forms the sums, the rounding and saturation
// stage, and the output register. A one-entry skid buffer beside the output register keeps
// the pipeline flowing while a result waits; the input is stalled only while that entry is
// occupied. There are no registers to configure.
module euler_to_quaternion_core #(
  parameter int ANGLE_BITS     = e2q_pkg::DEF_ANGLE_BITS,
  parameter int COMPONENT_BITS = e2q_pkg::DEF_COMPONENT_BITS,
  localparam int IN_DATA_W  = ((e2q_pkg::NUM_ANGLES * ANGLE_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((e2q_pkg::NUM_COMPS * COMPONENT_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // angle_x, angle_y, angle_z
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // quat_w, quat_x, quat_y, quat_z
);
  import e2q_pkg::*;

  localparam int COMP_BUS_W = NUM_COMPS * COMPONENT_BITS;

  logic                  pipe_en;
  logic [ANGLE_BITS-1:0] angle [NUM_ANGLES];
  logic                  trig_valid;
  trig_t                 trig [NUM_ANGLES];
  logic                  quat_valid;
  logic [COMP_BUS_W-1:0] quat_bus;
  logic [COMP_BUS_W-1:0] out_bus;

  // Unpack the angles from the input word.
  for (genvar l = 0; l < NUM_ANGLES; l++) begin : g_unpack
    assign angle[l] = s_axis_tdata[l*ANGLE_BITS +: ANGLE_BITS];
  end

  assign s_axis_tready = pipe_en;

  e2q_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s_axis_tvalid),
    .angle_i (angle),
    .valid_o (trig_valid),
    .trig_o  (trig)
  );

  e2q_quat #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_quat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (trig_valid),
    .trig_i  (trig),
    .valid_o (quat_valid),
    .comp_o  (quat_bus)
  );

  e2q_out_skid #(
    .DATA_W (COMP_BUS_W)
  ) u_out_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (quat_valid),
    .data_i  (quat_bus),
    .ready_o (pipe_en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_bus)
  );

  // Pad the result word to whole bytes.
  assign m_axis_tdata = OUT_DATA_W'(out_bus);

  // The input only stalls while a result is parked at the output.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // Once the parked word moves out, the input reopens on the next cycle.
  a_stall_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !s_axis_tready) |=> s_axis_tready)
    else $error("input stayed stalled after the output drained");

  // A stalled pipeline must keep a result on offer.
  a_stall_keeps_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s_axis_tready && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while the pipeline was stalled");

endmodule
